[rtl/aligned_first_fit_range_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the aligned first-fit range allocator
// Shared property forms; clk and rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define ALIGNED_FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define AFF_CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aff same-cycle check failed");

// Next-cycle implication
`define AFF_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aff next-cycle check failed");

`endif

[rtl/aff_pkg.sv]
// ----------------------------------------------------------------------------
// aff_pkg
// Shared constants and codes for the aligned first-fit range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package aff_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int SIZE_BITS_DEF  = 32;

    localparam int ADDR_W    = 40;
    localparam int PORT_W    = 32;
    localparam int SLOT_W    = 6;
    localparam int ALIGN_MAX = 16;
    localparam int AMASK_W   = 16;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 64;

    // request codes
    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_FREE     = 2'd1;
    localparam logic [1:0] REQ_FREE_ALL = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOSPACE  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // register index (paddr bit 3)
    localparam logic CFG_BUFFER_SIZE = 1'b0;
    localparam logic CFG_BASE_OFFSET = 1'b1;

    // cell operations
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_ROT  = 2'd1;
    localparam cell_op_t CELL_INS  = 2'd2;
    localparam cell_op_t CELL_DEL  = 2'd3;

endpackage

`default_nettype wire

[rtl/aff_cell.sv]
// ----------------------------------------------------------------------------
// aff_cell
// One table entry: rotates toward the head, or shifts for insert/delete.
// ----------------------------------------------------------------------------
`default_nettype none

module aff_cell import aff_pkg::*; #(
    parameter int SW    = SIZE_BITS_DEF,
    parameter int IW    = 6,
    parameter int INDEX = 0
) (
    input  wire logic          clk,
    input  wire cell_op_t      op,
    input  wire logic [IW-1:0] pos,
    input  wire logic [SW-1:0] left_start,
    input  wire logic [SW-1:0] left_len,
    input  wire logic [SW-1:0] right_start,
    input  wire logic [SW-1:0] right_len,
    input  wire logic [SW-1:0] new_start,
    input  wire logic [SW-1:0] new_len,
    output logic      [SW-1:0] start_q,
    output logic      [SW-1:0] len_q
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [SW-1:0] start_reg, start_next;
    logic [SW-1:0] len_reg, len_next;

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        unique case (op)
            CELL_HOLD: ;
            CELL_ROT:
            begin
                start_next = right_start;
                len_next   = right_len;
            end
            CELL_INS:
            begin
                if (MY_IDX > pos)
                begin
                    start_next = left_start;
                    len_next   = left_len;
                end
                else if (MY_IDX == pos)
                begin
                    start_next = new_start;
                    len_next   = new_len;
                end
            end
            CELL_DEL:
            begin
                if (MY_IDX >= pos)
                begin
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign start_q = start_reg;
    assign len_q   = len_reg;

endmodule

`default_nettype wire

[rtl/aff_chain.sv]
// ----------------------------------------------------------------------------
// aff_chain
// Ring of table cells; cell 0 is the head seen by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module aff_chain import aff_pkg::*; #(
    parameter int N  = MAX_RANGES_DEF,
    parameter int SW = SIZE_BITS_DEF,
    parameter int IW = $clog2(MAX_RANGES_DEF)
) (
    input  wire logic          clk,
    input  wire cell_op_t      op,
    input  wire logic [IW-1:0] pos,
    input  wire logic [SW-1:0] new_start,
    input  wire logic [SW-1:0] new_len,
    output logic      [SW-1:0] head_start,
    output logic      [SW-1:0] head_len
);

    logic [SW-1:0] start_w [N];
    logic [SW-1:0] len_w   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        localparam int LEFT  = (k == 0) ? N - 1 : k - 1;
        localparam int RIGHT = (k == N - 1) ? 0 : k + 1;

        aff_cell #(
            .SW    (SW),
            .IW    (IW),
            .INDEX (k)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .pos         (pos),
            .left_start  (start_w[LEFT]),
            .left_len    (len_w[LEFT]),
            .right_start (start_w[RIGHT]),
            .right_len   (len_w[RIGHT]),
            .new_start   (new_start),
            .new_len     (new_len),
            .start_q     (start_w[k]),
            .len_q       (len_w[k])
        );
    end

    assign head_start = start_w[0];
    assign head_len   = len_w[0];

endmodule

`default_nettype wire

[rtl/aligned_first_fit_range_allocator.sv]
// ----------------------------------------------------------------------------
// aligned_first_fit_range_allocator
// First-fit allocator of aligned ranges in a buffer, table held in a cell ring.
// ----------------------------------------------------------------------------
// Usage:
//   Config: APB port. buffer_size at 0x0, base_offset at 0x8 (64-bit data).
//     Writing buffer_size empties the table and frees the whole buffer.
//     Write only while busy is low and no result is pending.
//   Request: drive req_type and its fields with start high; the item is
//     taken on a clock edge where start is high and busy is low.
//   Result: done pulses for one cycle with all result fields valid; the
//     receiver cannot stall it, so it must take the item in that cycle.
//   Walks (N = MAX_RANGES): every walk rotates the whole ring of N cells
//     through the head, one entry a cycle.
//     allocate ok / free ok : search, update, gap rescan
//     allocate fail / miss  : search only, no update or rescan
//     table full, free all, unknown type : no walk
//   One item at a time; a new item may be taken in the cycle done is high.
//   Reset: table empty, buffer_size and base_offset zero, no results.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_first_fit_range_allocator import aff_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    // request
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        req_type,
    input  wire logic [PORT_W-1:0] alloc_size,
    input  wire logic [4:0]        align_log2,
    input  wire logic [PORT_W-1:0] free_offset,
    // result
    output logic                   done,
    output logic [1:0]             status,
    output logic [PORT_W-1:0]      placed_offset,
    output logic [ADDR_W-1:0]      absolute_offset,
    output logic [SLOT_W-1:0]      slot_index,
    output logic [PORT_W-1:0]      free_total,
    output logic [PORT_W-1:0]      largest_gap_offset,
    output logic [PORT_W-1:0]      largest_gap_size
);

    localparam int N  = MAX_RANGES;
    localparam int SW = SIZE_BITS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int XW = SW + AMASK_W + 2;   // room for end + alignment carry

    localparam logic [IW-1:0] LAST_STEP = IW'(N - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(N);

    // controller states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_PLACE  = 3'd2;
    localparam logic [2:0] S_FIND   = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_RESCAN = 3'd5;
    localparam logic [2:0] S_TAIL   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [IW-1:0]      step_reg, step_next;
    logic [1:0]         req_reg, req_next;
    logic [SW-1:0]      size_reg, size_next;
    logic [AMASK_W-1:0] amask_reg, amask_next;
    logic [SW-1:0]      foff_reg, foff_next;
    logic [SW-1:0]      prev_reg, prev_next;
    logic               ovf_reg, ovf_next;      // alignment overflow / free walk over
    logic               found_reg, found_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic [SW-1:0]      hlen_reg, hlen_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SW-1:0]      free_reg, free_next;
    logic [SW-1:0]      bstart_reg, bstart_next;
    logic [SW-1:0]      blen_reg, blen_next;
    logic [SW-1:0]      bsize_reg, bsize_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [1:0]         stat_reg, stat_next;
    logic [SW-1:0]      placed_reg, placed_next;
    logic [IW-1:0]      slot_reg, slot_next;

    logic               done_reg;
    logic [1:0]         status_reg;
    logic [PORT_W-1:0]  placed_out_reg;
    logic [ADDR_W-1:0]  abs_out_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [PORT_W-1:0]  free_out_reg;
    logic [PORT_W-1:0]  gap_off_out_reg;
    logic [PORT_W-1:0]  gap_len_out_reg;

    cell_op_t           cell_op;
    logic [IW-1:0]      cell_pos;
    logic [SW-1:0]      head_start, head_len;

    logic               accept, cfg_wr;
    logic               active, last_step;
    logic [XW-1:0]      end_x, align_x;
    logic               ovf_now, fits_now, tail_fits;
    logic [SW-1:0]      gap_now;
    logic [4:0]         alog_sat;

    aff_chain #(
        .N  (N),
        .SW (SW),
        .IW (IW)
    ) u_chain (
        .clk        (clk),
        .op         (cell_op),
        .pos        (cell_pos),
        .new_start  (prev_reg),
        .new_len    (size_reg),
        .head_start (head_start),
        .head_len   (head_len)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign active    = CW'(step_reg) < count_reg;
    assign last_step = (step_reg == LAST_STEP);
    assign alog_sat  = (align_log2 > 5'(ALIGN_MAX)) ? 5'(ALIGN_MAX) : align_log2;

    // end of head range, rounded up to the alignment
    assign end_x    = XW'(head_start) + XW'(head_len);
    assign align_x  = (end_x + XW'(amask_reg)) & ~XW'(amask_reg);
    assign ovf_now  = |align_x[XW-1:SW];
    assign fits_now = !ovf_reg && (prev_reg <= head_start)
                      && ((head_start - prev_reg) >= size_reg);
    assign tail_fits = !ovf_reg && (prev_reg <= bsize_reg)
                       && ((bsize_reg - prev_reg) >= size_reg);
    assign gap_now  = (head_start > prev_reg) ? (head_start - prev_reg) : '0;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        req_next    = req_reg;
        size_next   = size_reg;
        amask_next  = amask_reg;
        foff_next   = foff_reg;
        prev_next   = prev_reg;
        ovf_next    = ovf_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        hlen_next   = hlen_reg;
        count_next  = count_reg;
        free_next   = free_reg;
        bstart_next = bstart_reg;
        blen_next   = blen_reg;
        bsize_next  = bsize_reg;
        base_next   = base_reg;
        stat_next   = stat_reg;
        placed_next = placed_reg;
        slot_next   = slot_reg;
        cell_op     = CELL_HOLD;
        cell_pos    = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req_type;
                    size_next   = SW'(alloc_size);
                    foff_next   = SW'(free_offset);
                    amask_next  = AMASK_W'((17'd1 << alog_sat) - 17'd1);
                    step_next   = '0;
                    prev_next   = '0;
                    ovf_next    = 1'b0;
                    found_next  = 1'b0;
                    stat_next   = STAT_OK;
                    placed_next = '0;
                    slot_next   = '0;
                    unique case (req_type)
                        REQ_ALLOC:
                        begin
                            if (count_reg >= FULL_CNT)
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        REQ_FREE:
                            state_next = S_FIND;
                        REQ_FREE_ALL:
                        begin
                            count_next  = '0;
                            free_next   = bsize_reg;
                            bstart_next = '0;
                            blen_next   = bsize_reg;
                            state_next  = S_FIN;
                        end
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end

            S_SEARCH:
            begin
                cell_op   = CELL_ROT;
                step_next = step_reg + 1'b1;
                if (active && !found_reg)
                begin
                    if (fits_now)
                    begin
                        found_next = 1'b1;
                        pos_next   = step_reg;
                    end
                    else if (ovf_now)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (!ovf_reg)
                    begin
                        prev_next = align_x[SW-1:0];
                    end
                end
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                if (found_reg || tail_fits)
                begin
                    cell_op     = CELL_INS;
                    cell_pos    = found_reg ? pos_reg : IW'(count_reg);
                    count_next  = count_reg + 1'b1;
                    free_next   = free_reg - size_reg;
                    placed_next = prev_reg;
                    slot_next   = cell_pos;
                    prev_next   = '0;
                    bstart_next = '0;
                    blen_next   = '0;
                    step_next   = '0;
                    state_next  = S_RESCAN;
                end
                else
                begin
                    stat_next  = STAT_NOSPACE;
                    state_next = S_FIN;
                end
            end

            S_FIND:
            begin
                cell_op   = CELL_ROT;
                step_next = step_reg + 1'b1;
                if (active && !ovf_reg)
                begin
                    if (head_start == foff_reg)
                    begin
                        found_next = 1'b1;
                        ovf_next   = 1'b1;
                        pos_next   = step_reg;
                        hlen_next  = head_len;
                    end
                    else if (head_start > foff_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = S_REMOVE;
                end
            end

            S_REMOVE:
            begin
                if (found_reg)
                begin
                    cell_op     = CELL_DEL;
                    count_next  = count_reg - 1'b1;
                    free_next   = free_reg + hlen_reg;
                    slot_next   = pos_reg;
                    prev_next   = '0;
                    bstart_next = '0;
                    blen_next   = '0;
                    step_next   = '0;
                    state_next  = S_RESCAN;
                end
                else
                begin
                    stat_next  = STAT_NOTFOUND;
                    state_next = S_FIN;
                end
            end

            S_RESCAN:
            begin
                cell_op   = CELL_ROT;
                step_next = step_reg + 1'b1;
                if (active)
                begin
                    if (gap_now > blen_reg)
                    begin
                        bstart_next = prev_reg;
                        blen_next   = gap_now;
                    end
                    prev_next = end_x[SW-1:0];
                end
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                if ((prev_reg < bsize_reg) && ((bsize_reg - prev_reg) > blen_reg))
                begin
                    bstart_next = prev_reg;
                    blen_next   = bsize_reg - prev_reg;
                end
                state_next = S_FIN;
            end

            S_FIN:
                state_next = S_IDLE;

            default:
                state_next = S_IDLE;
        endcase

        // the user must make register writes only while idle; the block does not enforce this
        if (cfg_wr)
        begin
            if (paddr[3] == CFG_BUFFER_SIZE)
            begin
                bsize_next  = SW'(pwdata[PORT_W-1:0]);
                count_next  = '0;
                free_next   = SW'(pwdata[PORT_W-1:0]);
                bstart_next = '0;
                blen_next   = SW'(pwdata[PORT_W-1:0]);
            end
            else
            begin
                base_next = pwdata[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            free_reg   <= '0;
            bstart_reg <= '0;
            blen_reg   <= '0;
            bsize_reg  <= '0;
            base_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            bstart_reg <= bstart_next;
            blen_reg   <= blen_next;
            bsize_reg  <= bsize_next;
            base_reg   <= base_next;
            done_reg   <= (state_reg == S_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        req_reg    <= req_next;
        size_reg   <= size_next;
        amask_reg  <= amask_next;
        foff_reg   <= foff_next;
        prev_reg   <= prev_next;
        ovf_reg    <= ovf_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        hlen_reg   <= hlen_next;
        stat_reg   <= stat_next;
        placed_reg <= placed_next;
        slot_reg   <= slot_next;
        if (state_reg == S_FIN)
        begin
            status_reg      <= stat_reg;
            placed_out_reg  <= PORT_W'(placed_reg);
            abs_out_reg     <= ((req_reg == REQ_ALLOC) && (stat_reg == STAT_OK))
                               ? base_reg + ADDR_W'(placed_reg) : '0;
            slot_out_reg    <= SLOT_W'(slot_reg);
            free_out_reg    <= PORT_W'(free_reg);
            gap_off_out_reg <= PORT_W'(bstart_reg);
            gap_len_out_reg <= PORT_W'(blen_reg);
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[3] == CFG_BASE_OFFSET) ? CFG_DW'(base_reg) : CFG_DW'(bsize_reg);

    assign done               = done_reg;
    assign status             = status_reg;
    assign placed_offset      = placed_out_reg;
    assign absolute_offset    = abs_out_reg;
    assign slot_index         = slot_out_reg;
    assign free_total         = free_out_reg;
    assign largest_gap_offset = gap_off_out_reg;
    assign largest_gap_size   = gap_len_out_reg;

endmodule

`default_nettype wire

[rtl/aff_checker.sv]
// ----------------------------------------------------------------------------
// aff_checker
// Port-level checks of the allocator request/result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aligned_first_fit_range_allocator_defines.svh"

module aff_checker import aff_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [1:0]        status,
    input wire logic [PORT_W-1:0] placed_offset,
    input wire logic [ADDR_W-1:0] absolute_offset,
    input wire logic [SLOT_W-1:0] slot_index
);

    // one result per item, never two in a row
    `AFF_CHK_NEXT(a_done_single, done, !done)
    // a taken item keeps the block busy
    `AFF_CHK_NEXT(a_accept_busy, start && !busy, busy)
    // a result follows a busy cycle
    `AFF_CHK_SAME(a_done_after_busy, done, $past(busy))
    // failed requests report no placement
    `AFF_CHK_SAME(a_fail_clean, done && (status != STAT_OK),
                  (placed_offset == '0) && (absolute_offset == '0) && (slot_index == '0))

endmodule

bind aligned_first_fit_range_allocator aff_checker u_aff_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .placed_offset   (placed_offset),
    .absolute_offset (absolute_offset),
    .slot_index      (slot_index)
);

`default_nettype wire
